// File: rtl/att_pkg.sv
package att_pkg;

  localparam int unsigned LEXEME_CAPACITY_DEFAULT = 8;
  localparam int unsigned LEX_BYTES = 7;
  localparam int unsigned MNEM_COUNT = 18;

  typedef enum logic [3:0] {
    KIND_EOL    = 4'd0,
    KIND_REG_A  = 4'd1,
    KIND_REG_B  = 4'd2,
    KIND_REG_I  = 4'd3,
    KIND_LBRACK = 4'd4,
    KIND_RBRACK = 4'd5,
    KIND_COMMA  = 4'd6,
    KIND_COLON  = 4'd7,
    KIND_LABEL  = 4'd8,
    KIND_INSTR  = 4'd9,
    KIND_CONST  = 4'd10,
    KIND_END    = 4'd11,
    KIND_ERROR  = 4'd12
  } att_kind_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] character;
  } att_char_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [55:0] lexeme_text;
    logic [2:0]  lexeme_length;
    logic [7:0]  opcode;
    logic        last_of_run;
  } att_token_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] op;
  } att_mnem_hit_t;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_H     = 8'h48;

  // mnemonic text packed with the first character in the low byte
  localparam logic [23:0] MNEM_TEXT [MNEM_COUNT] = '{
    {"D", "D", "A"}, {"B", "U", "S"}, {"P", "M", "C"}, {"C", "N", "I"},
    {"C", "E", "D"}, {"D", "N", "A"}, {8'h00, "R", "O"}, {"T", "O", "N"},
    {"R", "H", "S"}, {"L", "H", "S"}, {"P", "M", "J"}, {8'h00, "Z", "J"},
    {8'h00, "S", "J"}, {8'h00, "C", "J"}, {8'h00, "O", "J"}, {8'h00, "P", "J"},
    {"V", "O", "M"}, {"P", "O", "N"}
  };

  localparam logic [2:0] MNEM_LEN [MNEM_COUNT] = '{
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd3,
    3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3
  };

  localparam logic [7:0] MNEM_OP [MNEM_COUNT] = '{
    8'h00, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60, 8'h70, 8'h80, 8'h90,
    8'hA0, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hB0, 8'hFF
  };

  function automatic att_mnem_hit_t mnem_lookup(input logic [55:0] text,
                                                input logic [2:0] len);
    att_mnem_hit_t r;
    r = '0;
    for (int i = 0; i < MNEM_COUNT; i++) begin
      if (len == MNEM_LEN[i] && text == {32'h0, MNEM_TEXT[i]}) begin
        r.hit = 1'b1;
        r.op  = MNEM_OP[i];
      end
    end
    return r;
  endfunction

  function automatic att_token_t plain_tok(input att_kind_t kind);
    att_token_t t;
    t = '0;
    t.token_kind = kind;
    return t;
  endfunction

endpackage

// File: rtl/assembly_text_tokenizer_core.sv
// Assembly source tokenizer. One byte (or an end mark) is taken per transfer on the char
// channel and turned into zero, one or two tokens on the token channel. An item is
// accepted when char_ready is high and its tokens appear in the result buffer the next
// cycle, so the block sustains one byte per cycle while each byte gives at most one token
// and tokens are taken at once. The two-entry result buffer sets the rate: a byte that
// gives two tokens holds char_ready low while the second token drains.
// After an error token the block takes bytes but emits nothing until reset.
module assembly_text_tokenizer_core
  import att_pkg::*;
#(
  parameter int unsigned LEXEME_CAPACITY = LEXEME_CAPACITY_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_ready,
  input  att_char_t  char_item,
  output logic       token_valid,
  input  logic       token_ready,
  output att_token_t token_item
);

  localparam logic [2:0] PUT_LIMIT =
    3'((LEXEME_CAPACITY - 1 < LEX_BYTES) ? LEXEME_CAPACITY - 1 : LEX_BYTES);

  typedef enum logic [4:0] {
    MODE_START    = 5'b00001,
    MODE_READING  = 5'b00010,
    MODE_PEND_REG = 5'b00100,
    MODE_PEND_H   = 5'b01000,
    MODE_HALTED   = 5'b10000
  } mode_t;

  mode_t       mode, mode_next;
  logic [55:0] store, store_next;
  logic [2:0]  count, count_next;
  logic [1:0]  preg, preg_next;

  att_token_t slot0, slot1;
  logic [1:0] fill;

  logic       accept, out_xfer;
  logic       is_end;
  logic [7:0] ch;
  logic       ch_blank, ch_letter, ch_alnum;
  logic [55:0] store_app;
  att_mnem_hit_t mnem;
  att_token_t    lex_tok;
  logic [7:0]    reg_letter;

  // start-mode action on the current byte
  logic       st_n;
  att_token_t st_tok;
  mode_t      st_mode;
  logic [55:0] st_store;
  logic [2:0] st_count;
  logic [1:0] st_preg;

  // reading-mode action on the current byte
  logic [1:0] rd_n;
  att_token_t rd_tok0, rd_tok1;
  mode_t      rd_mode;
  logic [55:0] rd_store;
  logic [2:0] rd_count;

  logic [1:0] n_res;
  att_token_t tok0, tok1, tok0_out, tok1_out;

  assign is_end = char_item.req_type;
  assign ch = (char_item.character >= "a" && char_item.character <= "z") ?
              char_item.character - 8'd32 : char_item.character;
  assign ch_blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                    (ch == CH_CR) || (ch == CH_VT) || (ch == CH_FF);
  assign ch_letter = (ch >= "A") && (ch <= "Z");
  assign ch_alnum  = ch_letter || ((ch >= "0") && (ch <= "9"));

  always_comb begin
    store_app = store;
    for (int i = 0; i < LEX_BYTES; i++) begin
      if (count == 3'(i)) store_app[8*i +: 8] = ch;
    end
  end

  assign mnem = mnem_lookup(store, count);

  always_comb begin
    lex_tok = '0;
    lex_tok.token_kind    = mnem.hit ? KIND_INSTR : KIND_LABEL;
    lex_tok.lexeme_text   = store;
    lex_tok.lexeme_length = count;
    lex_tok.opcode        = mnem.hit ? mnem.op : 8'h00;
  end

  always_comb begin
    unique case (preg)
      2'd2:    reg_letter = "B";
      2'd3:    reg_letter = "I";
      default: reg_letter = "A";
    endcase
  end

  always_comb begin
    st_n     = 1'b0;
    st_tok   = plain_tok(KIND_EOL);
    st_mode  = MODE_START;
    st_store = '0;
    st_count = '0;
    st_preg  = '0;
    priority if (is_end) begin
      st_n   = 1'b1;
      st_tok = plain_tok(KIND_END);
    end else if (ch == CH_LF) begin
      st_n   = 1'b1;
      st_tok = plain_tok(KIND_EOL);
    end else if (ch_blank) begin
      // other blanks are skipped
      st_n = 1'b0;
    end else if (ch == "A") begin
      st_mode = MODE_PEND_REG;
      st_preg = 2'd1;
    end else if (ch == "B") begin
      st_mode = MODE_PEND_REG;
      st_preg = 2'd2;
    end else if (ch == "I") begin
      st_mode = MODE_PEND_REG;
      st_preg = 2'd3;
    end else if (ch == "[") begin
      st_n   = 1'b1;
      st_tok = plain_tok(KIND_LBRACK);
    end else if (ch == "]") begin
      st_n   = 1'b1;
      st_tok = plain_tok(KIND_RBRACK);
    end else if (ch == ",") begin
      st_n   = 1'b1;
      st_tok = plain_tok(KIND_COMMA);
    end else if (ch == ":") begin
      st_n   = 1'b1;
      st_tok = plain_tok(KIND_COLON);
    end else if (ch_alnum) begin
      st_mode  = MODE_READING;
      st_store = {48'h0, ch};
      st_count = 3'd1;
    end else begin
      st_n    = 1'b1;
      st_tok  = plain_tok(KIND_ERROR);
      st_mode = MODE_HALTED;
    end
  end

  always_comb begin
    rd_n     = 2'd0;
    rd_tok0  = plain_tok(KIND_ERROR);
    rd_tok1  = plain_tok(KIND_ERROR);
    rd_mode  = MODE_READING;
    rd_store = store;
    rd_count = count;
    priority if (!is_end && count == 3'd2 && ch == CH_H) begin
      // possible constant: wait for its delimiter
      rd_mode  = MODE_PEND_H;
      rd_store = store_app;
      rd_count = count + 3'd1;
    end else if (!is_end && ch_alnum) begin
      if (count >= PUT_LIMIT) begin
        rd_n     = 2'd1;
        rd_mode  = MODE_HALTED;
        rd_store = '0;
        rd_count = '0;
      end else begin
        rd_store = store_app;
        rd_count = count + 3'd1;
      end
    end else if (is_end || ch_blank) begin
      rd_tok0  = lex_tok;
      rd_mode  = MODE_START;
      rd_store = '0;
      rd_count = '0;
      if (is_end) begin
        rd_n    = 2'd2;
        rd_tok1 = plain_tok(KIND_END);
      end else if (ch == CH_LF) begin
        rd_n    = 2'd2;
        rd_tok1 = plain_tok(KIND_EOL);
      end else begin
        rd_n = 2'd1;
      end
    end else if (ch == ":") begin
      // a lexeme before a colon is always a label
      rd_n                = 2'd2;
      rd_tok0             = lex_tok;
      rd_tok0.token_kind  = KIND_LABEL;
      rd_tok0.opcode      = 8'h00;
      rd_tok1             = plain_tok(KIND_COLON);
      rd_mode             = MODE_START;
      rd_store            = '0;
      rd_count            = '0;
    end else begin
      rd_n     = 2'd1;
      rd_mode  = MODE_HALTED;
      rd_store = '0;
      rd_count = '0;
    end
  end

  always_comb begin
    n_res      = 2'd0;
    tok0       = plain_tok(KIND_ERROR);
    tok1       = plain_tok(KIND_ERROR);
    mode_next  = mode;
    store_next = store;
    count_next = count;
    preg_next  = preg;
    unique case (mode)
      MODE_START: begin
        n_res      = {1'b0, st_n};
        tok0       = st_tok;
        mode_next  = st_mode;
        store_next = st_store;
        count_next = st_count;
        preg_next  = st_preg;
      end
      MODE_READING: begin
        n_res      = rd_n;
        tok0       = rd_tok0;
        tok1       = rd_tok1;
        mode_next  = rd_mode;
        store_next = rd_store;
        count_next = rd_count;
      end
      MODE_PEND_REG: begin
        if (!is_end && ch_letter) begin
          // the register letter was the start of a longer lexeme
          mode_next  = MODE_READING;
          store_next = {40'h0, ch, reg_letter};
          count_next = 3'd2;
          preg_next  = '0;
        end else begin
          n_res      = st_n ? 2'd2 : 2'd1;
          tok0       = plain_tok((preg == 2'd0) ? KIND_REG_A : att_kind_t'({2'b00, preg}));
          tok1       = st_tok;
          mode_next  = st_mode;
          store_next = st_store;
          count_next = st_count;
          preg_next  = st_preg;
        end
      end
      MODE_PEND_H: begin
        if (!is_end && (ch_blank || ch == ",")) begin
          n_res              = st_n ? 2'd2 : 2'd1;
          tok0               = lex_tok;
          tok0.token_kind    = KIND_CONST;
          tok0.opcode        = 8'h00;
          tok1               = st_tok;
          mode_next          = st_mode;
          store_next         = st_store;
          count_next         = st_count;
          preg_next          = st_preg;
        end else begin
          n_res      = rd_n;
          tok0       = rd_tok0;
          tok1       = rd_tok1;
          mode_next  = rd_mode;
          store_next = rd_store;
          count_next = rd_count;
        end
      end
      default: begin
        mode_next = MODE_HALTED;
      end
    endcase
  end

  always_comb begin
    tok0_out             = tok0;
    tok0_out.last_of_run = (n_res == 2'd1);
    tok1_out             = tok1;
    tok1_out.last_of_run = 1'b1;
  end

  // a new item is taken only when the result buffer is empty by the next edge
  assign char_ready  = (fill == 2'd0) || (fill == 2'd1 && token_ready);
  assign accept      = char_valid && char_ready;
  assign token_valid = (fill != 2'd0);
  assign out_xfer    = token_valid && token_ready;
  assign token_item  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_START;
      store <= '0;
      count <= '0;
      preg  <= '0;
      fill  <= '0;
    end else begin
      if (accept) begin
        mode  <= mode_next;
        store <= store_next;
        count <= count_next;
        preg  <= preg_next;
        fill  <= n_res;
      end else if (out_xfer) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot0 <= tok0_out;
      slot1 <= tok1_out;
    end else if (out_xfer) begin
      slot0 <= slot1;
    end
  end

endmodule

// File: rtl/att_checker.sv
module att_checker
  import att_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_ready,
  input att_char_t  char_item,
  input logic       token_valid,
  input logic       token_ready,
  input att_token_t token_item
);

  // a stalled token holds its payload
  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token_item))
    else $error("token payload changed while stalled");

  // no new byte while a token waits
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |-> !char_ready)
    else $error("byte accepted while a token is stalled");

  // an error token is the last thing the block says
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_ready && token_item.token_kind == KIND_ERROR
    |=> !token_valid)
    else $error("token emitted after an error");

  // only lexeme tokens carry text, and only instructions carry an opcode
  a_plain_fields: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_item.token_kind != KIND_LABEL &&
    token_item.token_kind != KIND_INSTR && token_item.token_kind != KIND_CONST
    |-> token_item.lexeme_length == 3'd0 && token_item.lexeme_text == 56'h0 &&
        token_item.opcode == 8'h00)
    else $error("punctuation token carries lexeme or opcode");

  // char_valid and char_item are visible to the bind but not checked here
  logic unused_in;
  assign unused_in = char_valid ^ (^char_item);

endmodule

bind assembly_text_tokenizer_core att_checker u_att_checker (.*);
